/* rtl/swpec_pkg.sv */
package swpec_pkg;

  // Number of timestamps kept in the history ring.
  localparam int unsigned HISTORY_DEPTH = 1024;

  // Width of a ring slot index.
  localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);

  // Width needed internally to hold a count from 0 up to HISTORY_DEPTH.
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);

  // Fixed field widths of the stream items and the register.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 11;

  // Output tdata: two count fields, padded up to whole bytes.
  localparam int unsigned OUT_FIELDS_W = 2 * COUNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Largest number of earlier entries one walk may visit.
  localparam logic [CNT_W-1:0] WALK_MAX = CNT_W'(HISTORY_DEPTH - 1);

  // Ring size as a count value, for the fill level saturation.
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(HISTORY_DEPTH);

  // Last slot index of the ring.
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);

  // Reset value of the window register, in seconds.
  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(60);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new item and start the walk
    logic rd_step;  // step the cursor back one slot and read it
    logic cmp;      // compare the returned entry and count on a hit
    logic finish;   // store the item, update the peak, load the result
  } swpec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_hist;  // the ring holds at least one earlier entry
    logic hit;       // the entry just read lies within the window
    logic more;      // further entries remain to be visited
  } swpec_sts_t;

endpackage

/* rtl/swpec_ram.sv */
module swpec_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/swpec_ctrl.sv */
module swpec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  swpec_pkg::swpec_sts_t sts,
  output swpec_pkg::swpec_cmd_t cmd
);

  import swpec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.has_hist ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = (sts.hit && sts.more) ? ST_READ : ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/swpec_dp.sv */
module swpec_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swpec_pkg::TIME_W-1:0]   cfg_wdata,
  input  logic [swpec_pkg::TIME_W-1:0]   event_time,
  input  swpec_pkg::swpec_cmd_t          cmd,
  output swpec_pkg::swpec_sts_t          sts,
  output logic [swpec_pkg::COUNT_W-1:0]  window_count,
  output logic [swpec_pkg::COUNT_W-1:0]  peak_count
);

  import swpec_pkg::*;

  logic [TIME_W-1:0] window_seconds;
  logic [TIME_W-1:0] now;
  logic [IDX_W-1:0]  write_slot;
  logic [IDX_W-1:0]  cursor;
  logic [IDX_W-1:0]  cursor_next;
  logic [CNT_W-1:0]  stored_entries;
  logic [CNT_W-1:0]  remaining;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  peak;
  logic [CNT_W-1:0]  peak_next;
  logic [TIME_W-1:0] past;
  logic [TIME_W:0]   diff;

  // History ring.
  swpec_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (write_slot),
    .wdata (now),
    .raddr (cursor_next),
    .rdata (past)
  );

  // The walk moves one slot back, wrapping below slot zero.
  assign cursor_next = (cursor == '0) ? LAST_SLOT : cursor - 1'b1;

  // Distance from the stored entry to the new time; the top bit marks an
  // entry later than the new event.
  assign diff = {1'b0, now} - {1'b0, past};

  assign sts.hit      = !diff[TIME_W] && (diff[TIME_W-1:0] <= window_seconds);
  assign sts.more     = (remaining != '0);
  assign sts.has_hist = (stored_entries != '0);

  assign peak_next = (count > peak) ? count : peak;

  // Window register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_seconds <= cfg_wdata;
    end
  end

  // Ring bookkeeping and running peak.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      stored_entries <= '0;
      peak           <= '0;
    end else if (cmd.finish) begin
      write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      if (stored_entries != FILL_MAX) begin
        stored_entries <= stored_entries + 1'b1;
      end
      peak <= peak_next;
    end
  end

  // Walk registers and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now       <= event_time;
      cursor    <= write_slot;
      count     <= CNT_W'(1);
      remaining <= (stored_entries > WALK_MAX) ? WALK_MAX : stored_entries;
    end
    if (cmd.rd_step) begin
      cursor    <= cursor_next;
      remaining <= remaining - 1'b1;
    end
    if (cmd.cmp && sts.hit) begin
      count <= count + 1'b1;
    end
    if (cmd.finish) begin
      window_count <= COUNT_W'(count);
      peak_count   <= COUNT_W'(peak_next);
    end
  end

endmodule

/* rtl/sliding_window_peak_event_count_top.sv */
// Sliding-window event counter with running peak. Each input item carries one
// event timestamp in whole seconds. The block walks back through a ring of the
// most recent timestamps, newest first, and counts those that lie from zero to
// window_seconds before the new event, stopping at the first one outside that
// range; one result item per input gives that count, the event itself
// included, and the largest count seen since reset. The new timestamp then
// is written to the ring, replacing the oldest entry once the ring is full. The
// count saturates at the ring depth. A walk visits at most the ring depth minus
// one earlier entries; it reads one ring entry at a time through the ring
// memory's single registered read port and then compares it. Items are
// handled one at a time; a finished result waits in an output register while
// the next item is accepted and walked. The window register may be written
// only while no item is in flight.
module sliding_window_peak_event_count_top (
  input  logic                              clk,
  input  logic                              rst,
  // Window register write.
  input  logic                              cfg_we,
  input  logic [swpec_pkg::TIME_W-1:0]      cfg_wdata,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [swpec_pkg::TIME_W-1:0]      s_axis_tdata,   // [31:0] event_time
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [swpec_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // [10:0] window_count,
                                                            // [21:11] peak_count
);

  import swpec_pkg::*;

  swpec_cmd_t        cmd;
  swpec_sts_t        sts;
  logic [COUNT_W-1:0] window_count;
  logic [COUNT_W-1:0] peak_count;

  // Sequencer for the walk and the result handshake.
  swpec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Ring, compare and counters.
  swpec_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .event_time   (s_axis_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .window_count (window_count),
    .peak_count   (peak_count)
  );

  // Pack the result fields, lowest field first, zero padded.
  assign m_axis_tdata = OUT_DATA_W'({peak_count, window_count});

endmodule
